// File: design/tswfc_pkg.sv
// ----------------------------------------------------------------------------
// tswfc_pkg
// Shared constants, codes and controller/datapath types of the frame cache.
// ----------------------------------------------------------------------------
package tswfc_pkg;

  localparam int NUM_STREAMS = 4;
  localparam int MAX_FRAMES  = 2048;
  localparam int FR_W        = $clog2(MAX_FRAMES);
  localparam int CNT_W       = FR_W + 1;
  localparam int STRM_W      = 2;
  localparam int ADDR_W      = STRM_W + FR_W;
  localparam int DEPTH       = NUM_STREAMS * MAX_FRAMES;
  localparam int TS_W        = 48;
  localparam int TAG_W       = 16;
  localparam int ENT_W       = TS_W + TAG_W;
  localparam int WIN_W       = 26;
  localparam int SP_W        = 20;
  localparam int EN_W        = 4;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 26;
  localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1000000);

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_DISABLED  = 2'd1,
    ST_REJECTED  = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW  = 2'd0,
    CFG_SPACING = 2'd1,
    CFG_ENABLE  = 2'd2,
    CFG_SPARE   = 2'd3
  } cfg_idx_t;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_EV_RD, S_EV_CHK, S_FD_RD, S_FD_CHK, S_SPACE,
    S_SH_INIT, S_SH_RD, S_SH_WR, S_LK_RD, S_LK_CHK, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RD, OP_EV_POP, OP_FD_STEP, OP_FD_NEXT, OP_DROP,
    OP_SH_INIT, OP_RD_J, OP_WR_J, OP_INS, OP_IDX_INC, OP_LK_HIT,
    OP_RES_DIS, OP_RES_REJ, OP_RES_NF
  } op_t;

  typedef struct packed {
    logic en;
    logic lookup;
    logic idx_lt_cnt;
    logic ev_ok;
    logic ev_hit;
    logic fd_le;
    logic lk_ge;
    logic reject;
    logic full;
    logic pos_zero;
    logic sh_more;
  } dp_stat_t;

endpackage

// File: design/tswfc_ctrl.sv
// ----------------------------------------------------------------------------
// tswfc_ctrl
// Sequencer: steps eviction, slot search, spacing check, shift insert, lookup.
// ----------------------------------------------------------------------------
module tswfc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  tswfc_pkg::dp_stat_t st,
  output tswfc_pkg::op_t      op,
  output logic                busy,
  output logic                done
);

  tswfc_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tswfc_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    op        = tswfc_pkg::OP_NONE;
    case (state_r)
      tswfc_pkg::S_IDLE: begin
        if (start) begin
          op        = tswfc_pkg::OP_LOAD;
          state_nxt = tswfc_pkg::S_CHECK;
        end
      end
      tswfc_pkg::S_CHECK: begin
        if (!st.en) begin
          op        = tswfc_pkg::OP_RES_DIS;
          state_nxt = tswfc_pkg::S_DONE;
        end else if (st.lookup) begin
          state_nxt = tswfc_pkg::S_LK_RD;
        end else begin
          state_nxt = tswfc_pkg::S_EV_RD;
        end
      end
      tswfc_pkg::S_EV_RD: begin
        if (st.ev_ok && st.idx_lt_cnt) begin
          op        = tswfc_pkg::OP_RD;
          state_nxt = tswfc_pkg::S_EV_CHK;
        end else begin
          state_nxt = tswfc_pkg::S_FD_RD;
        end
      end
      tswfc_pkg::S_EV_CHK: begin
        if (st.ev_hit) begin
          op        = tswfc_pkg::OP_EV_POP;
          state_nxt = tswfc_pkg::S_EV_RD;
        end else begin
          state_nxt = tswfc_pkg::S_FD_RD;
        end
      end
      tswfc_pkg::S_FD_RD: begin
        if (st.idx_lt_cnt) begin
          op        = tswfc_pkg::OP_RD;
          state_nxt = tswfc_pkg::S_FD_CHK;
        end else begin
          state_nxt = tswfc_pkg::S_SPACE;
        end
      end
      tswfc_pkg::S_FD_CHK: begin
        if (st.fd_le) begin
          op        = tswfc_pkg::OP_FD_STEP;
          state_nxt = tswfc_pkg::S_FD_RD;
        end else begin
          op        = tswfc_pkg::OP_FD_NEXT;
          state_nxt = tswfc_pkg::S_SPACE;
        end
      end
      tswfc_pkg::S_SPACE: begin
        if (st.reject) begin
          op        = tswfc_pkg::OP_RES_REJ;
          state_nxt = tswfc_pkg::S_DONE;
        end else if (st.full && st.pos_zero) begin
          state_nxt = tswfc_pkg::S_DONE;
        end else if (st.full) begin
          op        = tswfc_pkg::OP_DROP;
          state_nxt = tswfc_pkg::S_SH_INIT;
        end else begin
          state_nxt = tswfc_pkg::S_SH_INIT;
        end
      end
      tswfc_pkg::S_SH_INIT: begin
        op        = tswfc_pkg::OP_SH_INIT;
        state_nxt = tswfc_pkg::S_SH_RD;
      end
      tswfc_pkg::S_SH_RD: begin
        if (st.sh_more) begin
          op        = tswfc_pkg::OP_RD_J;
          state_nxt = tswfc_pkg::S_SH_WR;
        end else begin
          op        = tswfc_pkg::OP_INS;
          state_nxt = tswfc_pkg::S_DONE;
        end
      end
      tswfc_pkg::S_SH_WR: begin
        op        = tswfc_pkg::OP_WR_J;
        state_nxt = tswfc_pkg::S_SH_RD;
      end
      tswfc_pkg::S_LK_RD: begin
        if (st.idx_lt_cnt) begin
          op        = tswfc_pkg::OP_RD;
          state_nxt = tswfc_pkg::S_LK_CHK;
        end else begin
          op        = tswfc_pkg::OP_RES_NF;
          state_nxt = tswfc_pkg::S_DONE;
        end
      end
      tswfc_pkg::S_LK_CHK: begin
        if (st.lk_ge) begin
          op        = tswfc_pkg::OP_LK_HIT;
          state_nxt = tswfc_pkg::S_DONE;
        end else begin
          op        = tswfc_pkg::OP_IDX_INC;
          state_nxt = tswfc_pkg::S_LK_RD;
        end
      end
      tswfc_pkg::S_DONE: begin
        state_nxt = tswfc_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tswfc_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != tswfc_pkg::S_IDLE);
  assign done = (state_r == tswfc_pkg::S_DONE);

endmodule

// File: design/tswfc_dp.sv
// ----------------------------------------------------------------------------
// tswfc_dp
// Datapath: entry memory as per-stream rings, counts, config and result regs.
// ----------------------------------------------------------------------------
module tswfc_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tswfc_pkg::op_t                        op,
  input  logic                                  in_cmd,
  input  logic [tswfc_pkg::STRM_W-1:0]          in_stream,
  input  logic [tswfc_pkg::TS_W-1:0]            in_timestamp,
  input  logic [tswfc_pkg::TAG_W-1:0]           in_frame_tag,
  input  logic                                  cfg_we,
  input  logic [tswfc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tswfc_pkg::CFG_DATA_W-1:0]      cfg_data,
  output tswfc_pkg::dp_stat_t                   st,
  output tswfc_pkg::status_t                    res_status,
  output logic [tswfc_pkg::TS_W-1:0]            res_ts,
  output logic [tswfc_pkg::TAG_W-1:0]           res_tag
);

  localparam int FR_W  = tswfc_pkg::FR_W;
  localparam int CNT_W = tswfc_pkg::CNT_W;
  localparam int TS_W  = tswfc_pkg::TS_W;
  localparam int TAG_W = tswfc_pkg::TAG_W;
  localparam int NS    = tswfc_pkg::NUM_STREAMS;

  logic [tswfc_pkg::ENT_W-1:0]  mem [tswfc_pkg::DEPTH];
  logic [tswfc_pkg::ENT_W-1:0]  rd_data_r;

  logic [FR_W-1:0]              head_r [NS];
  logic [CNT_W-1:0]             cnt_r  [NS];
  logic [tswfc_pkg::WIN_W-1:0]  win_r;
  logic [tswfc_pkg::SP_W-1:0]   sp_r;
  logic [tswfc_pkg::EN_W-1:0]   en_r;

  logic                         cmd_r;
  logic [tswfc_pkg::STRM_W-1:0] strm_r;
  logic [TS_W-1:0]              ts_r;
  logic [TAG_W-1:0]             tag_r;
  logic [CNT_W-1:0]             idx_r;
  logic [CNT_W-1:0]             j_r;
  logic [TS_W-1:0]              prev_r;
  logic [TS_W-1:0]              next_r;
  tswfc_pkg::status_t           stat_r;
  logic [TS_W-1:0]              fts_r;
  logic [TAG_W-1:0]             ftag_r;

  logic [FR_W-1:0]              head_c;
  logic [CNT_W-1:0]             cnt_c;
  logic [CNT_W-1:0]             off;
  logic [FR_W-1:0]              slot;
  logic [tswfc_pkg::ADDR_W-1:0] addr;
  logic [TS_W-1:0]              rd_ts;
  logic [TS_W-1:0]              win_ext;
  logic [TS_W-1:0]              sp_ext;
  logic [TS_W-1:0]              d_prev;
  logic [TS_W-1:0]              d_next;

  assign head_c  = head_r[strm_r];
  assign cnt_c   = cnt_r[strm_r];
  assign rd_ts   = rd_data_r[tswfc_pkg::ENT_W-1:TAG_W];
  assign win_ext = TS_W'(win_r);
  assign sp_ext  = TS_W'(sp_r);
  assign d_prev  = ts_r - prev_r;
  assign d_next  = next_r - ts_r;

  always_comb begin
    case (op)
      tswfc_pkg::OP_RD_J: off = j_r - CNT_W'(1);
      tswfc_pkg::OP_WR_J: off = j_r;
      default:            off = idx_r;
    endcase
  end
  assign slot = head_c + off[FR_W-1:0];
  assign addr = {strm_r, slot};

  always_comb begin
    st.en         = (32'(strm_r) < NS) && en_r[strm_r];
    st.lookup     = (cmd_r == tswfc_pkg::CMD_LOOKUP);
    st.idx_lt_cnt = (idx_r < cnt_c);
    st.ev_ok      = (ts_r >= win_ext);
    st.ev_hit     = (rd_ts <= (ts_r - win_ext));
    st.fd_le      = (rd_ts <= ts_r);
    st.lk_ge      = (rd_ts >= ts_r);
    st.reject     = (sp_r != '0) &&
                    (((idx_r != '0) && (d_prev < sp_ext)) ||
                     ((idx_r < cnt_c) && (d_next < sp_ext)));
    st.full       = (cnt_c == CNT_W'(tswfc_pkg::MAX_FRAMES));
    st.pos_zero   = (idx_r == '0);
    st.sh_more    = (j_r > idx_r);
  end

  // entry memory: one read, one write port
  always_ff @(posedge clk) begin
    if (op == tswfc_pkg::OP_RD || op == tswfc_pkg::OP_RD_J) begin
      rd_data_r <= mem[addr];
    end
    if (op == tswfc_pkg::OP_WR_J) begin
      mem[addr] <= rd_data_r;
    end else if (op == tswfc_pkg::OP_INS) begin
      mem[addr] <= {ts_r, tag_r};
    end
  end

  // per-stream ring state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        head_r[s] <= '0;
        cnt_r[s]  <= '0;
      end
      win_r <= tswfc_pkg::WIN_RESET;
      sp_r  <= '0;
      en_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (tswfc_pkg::cfg_idx_t'(cfg_index))
          tswfc_pkg::CFG_WINDOW:  win_r <= cfg_data;
          tswfc_pkg::CFG_SPACING: sp_r  <= cfg_data[tswfc_pkg::SP_W-1:0];
          tswfc_pkg::CFG_ENABLE: begin
            en_r <= cfg_data[tswfc_pkg::EN_W-1:0];
            for (int s = 0; s < NS; s++) begin
              if (!cfg_data[s]) begin
                cnt_r[s] <= '0;
              end
            end
          end
          default: ;
        endcase
      end
      case (op)
        tswfc_pkg::OP_EV_POP, tswfc_pkg::OP_DROP: begin
          head_r[strm_r] <= head_c + FR_W'(1);
          cnt_r[strm_r]  <= cnt_c - CNT_W'(1);
        end
        tswfc_pkg::OP_INS: cnt_r[strm_r] <= cnt_c + CNT_W'(1);
        default: ;
      endcase
    end
  end

  // item registers
  always_ff @(posedge clk) begin
    case (op)
      tswfc_pkg::OP_LOAD: begin
        cmd_r  <= in_cmd;
        strm_r <= in_stream;
        ts_r   <= in_timestamp;
        tag_r  <= in_frame_tag;
        idx_r  <= '0;
        prev_r <= '0;
        next_r <= '0;
        stat_r <= tswfc_pkg::ST_OK;
        fts_r  <= '0;
        ftag_r <= '0;
      end
      tswfc_pkg::OP_FD_STEP: begin
        prev_r <= rd_ts;
        idx_r  <= idx_r + CNT_W'(1);
      end
      tswfc_pkg::OP_FD_NEXT: next_r <= rd_ts;
      tswfc_pkg::OP_DROP:    idx_r  <= idx_r - CNT_W'(1);
      tswfc_pkg::OP_SH_INIT: j_r    <= cnt_c;
      tswfc_pkg::OP_WR_J:    j_r    <= j_r - CNT_W'(1);
      tswfc_pkg::OP_IDX_INC: idx_r  <= idx_r + CNT_W'(1);
      tswfc_pkg::OP_LK_HIT: begin
        fts_r  <= rd_ts;
        ftag_r <= rd_data_r[TAG_W-1:0];
      end
      tswfc_pkg::OP_RES_DIS: stat_r <= tswfc_pkg::ST_DISABLED;
      tswfc_pkg::OP_RES_REJ: stat_r <= tswfc_pkg::ST_REJECTED;
      tswfc_pkg::OP_RES_NF:  stat_r <= tswfc_pkg::ST_NOT_FOUND;
      default: ;
    endcase
  end

  assign res_status = stat_r;
  assign res_ts     = fts_r;
  assign res_tag    = ftag_r;

endmodule

// File: design/timestamp_window_frame_cache.sv
// ----------------------------------------------------------------------------
// timestamp_window_frame_cache
// Per-stream sorted frame cache with window eviction, spacing limit, lookup.
// Latency grows with the number of entries read and entries shifted.
// One item at a time; the sequential scan over the entry memory sets the rate.
// Result beats cannot be stalled by the receiver; each lasts one cycle.
// Reset clears counts, ring heads, spacing and enables, and sets the window
// to WIN_RESET; entries need no clearing pass.
// ----------------------------------------------------------------------------
module timestamp_window_frame_cache (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_cmd,
  input  logic [tswfc_pkg::STRM_W-1:0]         in_stream,
  input  logic [tswfc_pkg::TS_W-1:0]           in_timestamp,
  input  logic [tswfc_pkg::TAG_W-1:0]          in_frame_tag,
  output logic                                 out_valid,
  output logic [1:0]                           out_status,
  output logic [tswfc_pkg::TS_W-1:0]           out_found_timestamp,
  output logic [tswfc_pkg::TAG_W-1:0]          out_found_tag,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tswfc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tswfc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  tswfc_pkg::dp_stat_t st;
  tswfc_pkg::op_t      op;
  tswfc_pkg::status_t  res_status;
  logic                done;

  assign cfg_ready = 1'b1;

  tswfc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .op    (op),
    .busy  (busy),
    .done  (done)
  );

  tswfc_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .op           (op),
    .in_cmd       (in_cmd),
    .in_stream    (in_stream),
    .in_timestamp (in_timestamp),
    .in_frame_tag (in_frame_tag),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .st           (st),
    .res_status   (res_status),
    .res_ts       (out_found_timestamp),
    .res_tag      (out_found_tag)
  );

  assign out_valid  = done;
  assign out_status = res_status;

  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat outside busy");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy held after result beat");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted item did not raise busy");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != tswfc_pkg::ST_OK |->
      out_found_timestamp == '0 && out_found_tag == '0)
    else $error("nonzero fields on non-ok result");

endmodule
